@@ hdl/scbp_pkg.sv @@
`default_nettype none

package scbp_pkg;

    // Class geometry
    localparam int SMALL_BLOCKS  = 256;
    localparam int MEDIUM_BLOCKS = 128;
    localparam int LARGE_BLOCKS  = 64;
    localparam int SMALL_BYTES   = 64;
    localparam int MEDIUM_BYTES  = 256;
    localparam int LARGE_BYTES   = 1024;
    localparam int REGION_ALIGN  = 16;

    // Field widths
    localparam int SIZE_W   = 12;
    localparam int OFFSET_W = 17;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 2;
    localparam int IN_USE_W = 9;

    // Area bounds, each area rounded up to the region alignment.
    localparam int SMALL_BEGIN  = 0;
    localparam int SMALL_END    = SMALL_BEGIN +
        ((SMALL_BLOCKS * SMALL_BYTES + REGION_ALIGN - 1) / REGION_ALIGN) * REGION_ALIGN;
    localparam int MEDIUM_BEGIN = SMALL_END;
    localparam int MEDIUM_END   = MEDIUM_BEGIN +
        ((MEDIUM_BLOCKS * MEDIUM_BYTES + REGION_ALIGN - 1) / REGION_ALIGN) * REGION_ALIGN;
    localparam int LARGE_BEGIN  = MEDIUM_END;
    localparam int LARGE_END    = LARGE_BEGIN +
        ((LARGE_BLOCKS * LARGE_BYTES + REGION_ALIGN - 1) / REGION_ALIGN) * REGION_ALIGN;

    // Per-class counters
    localparam int NUM_CLASSES = 3;
    localparam int CLASS_IDX_W = $clog2(NUM_CLASSES);
    localparam int MAX_BLOCKS  =
        (SMALL_BLOCKS > MEDIUM_BLOCKS) ?
            ((SMALL_BLOCKS > LARGE_BLOCKS) ? SMALL_BLOCKS : LARGE_BLOCKS) :
            ((MEDIUM_BLOCKS > LARGE_BLOCKS) ? MEDIUM_BLOCKS : LARGE_BLOCKS);
    localparam int COUNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int BYTES_W = $clog2(LARGE_BYTES + 1);
    localparam int CMP_W   = (SIZE_W > BYTES_W) ? SIZE_W + 1 : BYTES_W;

    // Shared stack memory: the three stacks sit one after another.
    localparam int MEM_DEPTH   = SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int SMALL_BASE  = 0;
    localparam int MEDIUM_BASE = SMALL_BLOCKS;
    localparam int LARGE_BASE  = SMALL_BLOCKS + MEDIUM_BLOCKS;

    // Commands
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE_IN_USE  = 3'd4;

    // Class codes
    localparam logic [CLASS_W-1:0] CLASS_SMALL  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_MEDIUM = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_LARGE  = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd3;

    typedef struct packed {
        logic                cmd;
        logic [SIZE_W-1:0]   request_size;
        logic [OFFSET_W-1:0] block_offset_in;
    } req_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] block_offset_out;
        logic [CLASS_W-1:0]  size_class;
        logic [IN_USE_W-1:0] in_use_count;
    } rsp_word_t;

    function automatic logic [COUNT_W-1:0] class_blocks(input logic [CLASS_IDX_W-1:0] c);
        unique case (c)
            CLASS_SMALL:  class_blocks = COUNT_W'(SMALL_BLOCKS);
            CLASS_MEDIUM: class_blocks = COUNT_W'(MEDIUM_BLOCKS);
            default:      class_blocks = COUNT_W'(LARGE_BLOCKS);
        endcase
    endfunction

    function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_IDX_W-1:0] c);
        unique case (c)
            CLASS_SMALL:  class_bytes = BYTES_W'(SMALL_BYTES);
            CLASS_MEDIUM: class_bytes = BYTES_W'(MEDIUM_BYTES);
            default:      class_bytes = BYTES_W'(LARGE_BYTES);
        endcase
    endfunction

    function automatic logic [31:0] area_begin(input logic [CLASS_IDX_W-1:0] c);
        unique case (c)
            CLASS_SMALL:  area_begin = 32'(SMALL_BEGIN);
            CLASS_MEDIUM: area_begin = 32'(MEDIUM_BEGIN);
            default:      area_begin = 32'(LARGE_BEGIN);
        endcase
    endfunction

    function automatic logic [31:0] area_end(input logic [CLASS_IDX_W-1:0] c);
        unique case (c)
            CLASS_SMALL:  area_end = 32'(SMALL_END);
            CLASS_MEDIUM: area_end = 32'(MEDIUM_END);
            default:      area_end = 32'(LARGE_END);
        endcase
    endfunction

    function automatic logic [MEM_AW-1:0] mem_base(input logic [CLASS_IDX_W-1:0] c);
        unique case (c)
            CLASS_SMALL:  mem_base = MEM_AW'(SMALL_BASE);
            CLASS_MEDIUM: mem_base = MEM_AW'(MEDIUM_BASE);
            default:      mem_base = MEM_AW'(LARGE_BASE);
        endcase
    endfunction

endpackage

`default_nettype wire

@@ hdl/scbp_ram.sv @@
`default_nettype none

module scbp_ram (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [scbp_pkg::MEM_AW-1:0]   wr_addr,
    input  wire logic [scbp_pkg::OFFSET_W-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [scbp_pkg::MEM_AW-1:0]   rd_addr,
    output logic      [scbp_pkg::OFFSET_W-1:0] rd_data
);

    logic [scbp_pkg::OFFSET_W-1:0] mem [scbp_pkg::MEM_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/size_class_block_pool.sv @@
// Pipeline: an accepted request word passes stage one, then the output register.
// Throughput: one word per cycle unless the output stalls; each successful word does
// one pop or push in the shared stack memory; counters update in the acceptance cycle.
// Reset: counters and valid flags clear at once and the block is ready in the first
// cycle; stack entries never written since reset read as their initial offsets.
`default_nettype none

module size_class_block_pool (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire scbp_pkg::req_word_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output scbp_pkg::rsp_word_t      rsp
);

    // Per-class counters: blocks in use and the highest use reached since reset.
    logic [scbp_pkg::COUNT_W-1:0] used_reg [scbp_pkg::NUM_CLASSES];
    logic [scbp_pkg::COUNT_W-1:0] used_next;
    logic [scbp_pkg::COUNT_W-1:0] hwm_reg  [scbp_pkg::NUM_CLASSES];
    logic [scbp_pkg::COUNT_W-1:0] hwm_next;

    // Stage one: result waiting for the memory read data.
    logic                s1_valid_reg;
    scbp_pkg::rsp_word_t s1_word_reg;
    scbp_pkg::rsp_word_t s1_word_next;
    logic                s1_use_mem_reg;
    logic                s1_use_mem_next;

    // Output register.
    logic                rsp_valid_reg;
    scbp_pkg::rsp_word_t rsp_word_reg;
    scbp_pkg::rsp_word_t rsp_word_next;

    logic                              accept;
    logic                              s1_move;
    logic [scbp_pkg::CLASS_W-1:0]      cls;
    logic [scbp_pkg::CLASS_IDX_W-1:0]  cidx;
    logic [scbp_pkg::COUNT_W-1:0]      used_cur;
    logic [scbp_pkg::COUNT_W-1:0]      blocks;
    logic [31:0]                       off_wide;
    logic [31:0]                       init_off;
    logic                              upd;
    logic                              mem_wr_en;
    logic                              mem_rd_en;
    logic [scbp_pkg::MEM_AW-1:0]       mem_wr_addr;
    logic [scbp_pkg::MEM_AW-1:0]       mem_rd_addr;
    logic [scbp_pkg::OFFSET_W-1:0]     mem_rd_data;
    logic [scbp_pkg::CMP_W-1:0]        size_ext;

    // Handshake: stage one moves on when the output register is free or being emptied.
    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_move;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_word_reg;

    // Class selection and the checks for one request word.
    always_comb
    begin
        size_ext = scbp_pkg::CMP_W'(req.request_size);
        if (size_ext <= scbp_pkg::CMP_W'(scbp_pkg::SMALL_BYTES))
        begin
            cls = scbp_pkg::CLASS_SMALL;
        end
        else if (size_ext <= scbp_pkg::CMP_W'(scbp_pkg::MEDIUM_BYTES))
        begin
            cls = scbp_pkg::CLASS_MEDIUM;
        end
        else if (size_ext <= scbp_pkg::CMP_W'(scbp_pkg::LARGE_BYTES))
        begin
            cls = scbp_pkg::CLASS_LARGE;
        end
        else
        begin
            cls = scbp_pkg::CLASS_NONE;
        end

        cidx     = (cls == scbp_pkg::CLASS_NONE) ? scbp_pkg::CLASS_IDX_W'(0)
                                                 : scbp_pkg::CLASS_IDX_W'(cls);
        used_cur = used_reg[cidx];
        blocks   = scbp_pkg::class_blocks(cidx);
        off_wide = 32'(req.block_offset_in);
        init_off = scbp_pkg::area_begin(cidx) +
                   32'(used_cur) * 32'(scbp_pkg::class_bytes(cidx));

        used_next       = used_cur;
        hwm_next        = hwm_reg[cidx];
        upd             = 1'b0;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_wr_addr     = scbp_pkg::mem_base(cidx) + scbp_pkg::MEM_AW'(used_cur - 1'b1);
        mem_rd_addr     = scbp_pkg::mem_base(cidx) + scbp_pkg::MEM_AW'(used_cur);
        s1_use_mem_next = 1'b0;

        s1_word_next.status           = scbp_pkg::ST_OK;
        s1_word_next.block_offset_out = '0;
        s1_word_next.size_class       = cls;
        s1_word_next.in_use_count     = '0;

        if (cls == scbp_pkg::CLASS_NONE)
        begin
            s1_word_next.status = scbp_pkg::ST_TOO_LARGE;
        end
        else if (req.cmd == scbp_pkg::CMD_ACQUIRE)
        begin
            if (used_cur >= blocks)
            begin
                s1_word_next.status = scbp_pkg::ST_EXHAUSTED;
            end
            else
            begin
                // Pop: the entry at this depth is in memory only if the stack was deeper before.
                used_next                     = used_cur + 1'b1;
                upd                           = 1'b1;
                mem_rd_en                     = 1'b1;
                s1_use_mem_next               = used_cur < hwm_reg[cidx];
                s1_word_next.block_offset_out = init_off[scbp_pkg::OFFSET_W-1:0];
                if (used_next > hwm_reg[cidx])
                begin
                    hwm_next = used_next;
                end
            end
        end
        else
        begin
            if (off_wide < scbp_pkg::area_begin(cidx) || off_wide >= scbp_pkg::area_end(cidx))
            begin
                s1_word_next.status = scbp_pkg::ST_OUT_OF_RANGE;
            end
            else if (used_cur == '0 || used_cur > blocks)
            begin
                s1_word_next.status = scbp_pkg::ST_NONE_IN_USE;
            end
            else
            begin
                // Push the released offset back on top.
                used_next = used_cur - 1'b1;
                upd       = 1'b1;
                mem_wr_en = 1'b1;
            end
        end

        if (cls != scbp_pkg::CLASS_NONE)
        begin
            s1_word_next.in_use_count = scbp_pkg::IN_USE_W'(used_next);
        end
    end

    scbp_ram u_ram (
        .clk     (clk),
        .wr_en   (accept && mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (req.block_offset_in),
        .rd_en   (accept && mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scbp_pkg::NUM_CLASSES; i++)
            begin
                used_reg[i] <= '0;
                hwm_reg[i]  <= '0;
            end
        end
        else if (accept && upd)
        begin
            used_reg[cidx] <= used_next;
            hwm_reg[cidx]  <= hwm_next;
        end
    end

    // Stage one valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg    <= s1_word_next;
            s1_use_mem_reg <= s1_use_mem_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Next output word: take the popped offset from memory where it was written there.
    always_comb
    begin
        rsp_word_next = s1_word_reg;
        if (s1_use_mem_reg)
        begin
            rsp_word_next.block_offset_out = mem_rd_data;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import scbp_pkg::*;

    localparam int RANDOM_WORDS   = 1925;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

    // One row of the directed table; a typed result is used only when has_fixed is set.
    typedef struct {
        req_word_t word;
        logic      has_fixed;
        rsp_word_t fixed;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_word_t rsp;

    // Typed expectation that travels alongside the request word being offered.
    logic      fixed_valid;
    rsp_word_t fixed_word;

    // Pool predictor state.
    bit [OFFSET_W-1:0] free_stack [NUM_CLASSES][MAX_BLOCKS];
    int                in_use [NUM_CLASSES];
    int                blk_count [NUM_CLASSES];
    int                blk_bytes [NUM_CLASSES];
    int                zone_lo [NUM_CLASSES];
    int                zone_hi [NUM_CLASSES];

    rsp_word_t         expected_q [$];
    bit [OFFSET_W-1:0] lent_offsets [$];
    dir_row_t          directed_rows [$];

    int  mismatch_count;
    int  words_sent;
    int  results_seen;
    int  quiet_cycles;
    int  phases_run;
    int  status_tally [5];
    logic calm;

    size_class_block_pool i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Put the pool into its reset state: every stack full, lowest offset on top.
    function automatic void pool_reset();
        blk_count = '{SMALL_BLOCKS, MEDIUM_BLOCKS, LARGE_BLOCKS};
        blk_bytes = '{SMALL_BYTES, MEDIUM_BYTES, LARGE_BYTES};
        zone_lo   = '{SMALL_BEGIN, MEDIUM_BEGIN, LARGE_BEGIN};
        zone_hi   = '{SMALL_END, MEDIUM_END, LARGE_END};
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            in_use[c] = 0;
            for (int i = 0; i < blk_count[c]; i++)
            begin
                free_stack[c][i] = OFFSET_W'(zone_lo[c] + (blk_count[c] - 1 - i) * blk_bytes[c]);
            end
        end
    endfunction

    // The smallest class whose block holds the requested size.
    function automatic logic [CLASS_W-1:0] class_for_size(input logic [SIZE_W-1:0] size);
        if (size <= SMALL_BYTES)
            return CLASS_SMALL;
        else if (size <= MEDIUM_BYTES)
            return CLASS_MEDIUM;
        else if (size <= LARGE_BYTES)
            return CLASS_LARGE;
        return CLASS_NONE;
    endfunction

    // Apply one request word to the predicted pool and return the result word it gives.
    function automatic rsp_word_t serve_request(input req_word_t w);
        rsp_word_t r;
        int        c;
        int        n;
        r            = '0;
        r.status     = ST_OK;
        r.size_class = class_for_size(w.request_size);
        if (r.size_class == CLASS_NONE)
        begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        c = int'(r.size_class);
        n = blk_count[c];
        if (w.cmd == CMD_ACQUIRE)
        begin
            if (in_use[c] >= n)
                r.status = ST_EXHAUSTED;
            else
            begin
                r.block_offset_out = free_stack[c][n - in_use[c] - 1];
                in_use[c]++;
            end
        end
        else if (w.block_offset_in < zone_lo[c] || w.block_offset_in >= zone_hi[c])
            r.status = ST_OUT_OF_RANGE;
        else if (in_use[c] == 0)
            r.status = ST_NONE_IN_USE;
        else
        begin
            // Range is the only check: unaligned or doubled offsets go back as given.
            free_stack[c][n - in_use[c]] = w.block_offset_in;
            in_use[c]--;
        end
        r.in_use_count = IN_USE_W'(in_use[c]);
        return r;
    endfunction

    function automatic void note_failure(input string what, input rsp_word_t want,
                                         input rsp_word_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected status %0d offset %0d class %0d count %0d, got status %0d offset %0d class %0d count %0d",
                     $realtime, what, want.status, want.block_offset_out, want.size_class,
                     want.in_use_count, got.status, got.block_offset_out, got.size_class,
                     got.in_use_count);
        end
    endfunction

    // Compare a result word with the oldest expectation, field by field.
    function automatic void check_result(input rsp_word_t got);
        rsp_word_t want;
        if (expected_q.size() == 0)
        begin
            note_failure("unexpected result word", '0, got);
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status || got.block_offset_out !== want.block_offset_out ||
            got.size_class !== want.size_class || got.in_use_count !== want.in_use_count)
        begin
            note_failure("result mismatch", want, got);
        end
    endfunction

    function automatic void add_row(input logic cmd, input int size, input int offset,
                                    input logic has_fixed, input logic [STATUS_W-1:0] st,
                                    input int offset_out, input logic [CLASS_W-1:0] sc,
                                    input int count);
        dir_row_t row;
        row.word.cmd                = cmd;
        row.word.request_size       = SIZE_W'(size);
        row.word.block_offset_in    = OFFSET_W'(offset);
        row.has_fixed               = has_fixed;
        row.fixed.status            = st;
        row.fixed.block_offset_out  = OFFSET_W'(offset_out);
        row.fixed.size_class        = sc;
        row.fixed.in_use_count      = IN_USE_W'(count);
        directed_rows.push_back(row);
    endfunction

    // Mostly no gap, some short ones, a few long; none at all during calm stretches.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SIZE_W-1:0] size_in_class(input int c);
        int lo;
        int hi;
        int r;
        lo = (c == 0) ? 0 : blk_bytes[c - 1] + 1;
        hi = blk_bytes[c];
        r  = $urandom_range(0, 9);
        if (r < 2)
            return SIZE_W'(lo);
        if (r < 4)
            return SIZE_W'(hi);
        return SIZE_W'($urandom_range(lo, hi));
    endfunction

    function automatic int zone_of(input bit [OFFSET_W-1:0] offset);
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (offset >= zone_lo[c] && offset < zone_hi[c])
                return c;
        end
        return 0;
    endfunction

    // Build one random request word: mostly acquires and releases of blocks really held,
    // with some stray releases and fully random words as noise.
    function automatic req_word_t random_word(input traffic_mode_t mode, input int focus);
        req_word_t w;
        int        r;
        int        c;
        int        idx;
        int        acquire_share;
        w.cmd             = CMD_ACQUIRE;
        w.request_size    = '0;
        w.block_offset_in = OFFSET_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < ((mode == MODE_MIX) ? 15 : 5))
        begin
            w.cmd          = ($urandom_range(0, 1) == 0) ? CMD_ACQUIRE : CMD_RELEASE;
            w.request_size = SIZE_W'($urandom);
            return w;
        end
        acquire_share = (mode == MODE_FILL) ? 95 : ((mode == MODE_DRAIN) ? 10 : 55);
        if ($urandom_range(0, 99) < acquire_share)
        begin
            c = (focus >= 0 && $urandom_range(0, 9) != 0) ? focus : $urandom_range(0, 2);
            w.request_size = size_in_class(c);
            return w;
        end
        w.cmd = CMD_RELEASE;
        if (lent_offsets.size() > 0 && $urandom_range(0, 19) != 0)
        begin
            idx               = $urandom_range(0, lent_offsets.size() - 1);
            w.block_offset_in = lent_offsets[idx];
            lent_offsets.delete(idx);
            c = zone_of(w.block_offset_in);
        end
        else
        begin
            // Stray release: a block not held, a second release or an unaligned offset.
            c = $urandom_range(0, 2);
            w.block_offset_in = OFFSET_W'($urandom_range(zone_lo[c], zone_hi[c] - 1));
        end
        w.request_size = size_in_class(c);
        return w;
    endfunction

    // Offer one request word and hold it until it is accepted.
    task automatic send_word(input req_word_t w, input logic has_fixed, input rsp_word_t fixed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req         <= w;
        fixed_valid <= has_fixed;
        fixed_word  <= fixed;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Switch between calm stretches without gaps and ordinary random idling.
    initial
    begin : calm_ctl
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Result side: random stalls of rsp_ready.
    initial
    begin : result_sink
        int stall;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Checking and prediction on accepted words, plus the watchdog.
    always @(posedge clk)
    begin : monitor
        rsp_word_t predicted;
        if (rst_n)
        begin
            // Results first: a result never belongs to a request taken at the same edge.
            if (rsp_valid && rsp_ready)
            begin
                check_result(rsp);
                results_seen++;
            end
            if (req_valid && req_ready)
            begin
                predicted = serve_request(req);
                status_tally[predicted.status]++;
                if (req.cmd == CMD_ACQUIRE && predicted.status == ST_OK)
                    lent_offsets.push_back(predicted.block_offset_out);
                expected_q.push_back(fixed_valid ? fixed_word : predicted);
                words_sent++;
            end
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", expected_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then phased random traffic.
    initial
    begin : stimulus
        traffic_mode_t mode;
        int            focus;
        int            phase_idx;
        int            phase_left;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        fixed_valid    = 1'b0;
        fixed_word     = '0;
        mismatch_count = 0;
        words_sent     = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        phases_run     = 0;
        status_tally   = '{0, 0, 0, 0, 0};
        mode           = MODE_MIX;
        focus          = -1;
        phase_idx      = 5;
        phase_left     = 0;
        pool_reset();

        //      cmd          size  offset  typed  status           offset class         count
        add_row(CMD_ACQUIRE,    0,      0, 1'b1, ST_OK,               0, CLASS_SMALL,  1);
        add_row(CMD_ACQUIRE,   64, 131071, 1'b1, ST_OK,              64, CLASS_SMALL,  2);
        add_row(CMD_ACQUIRE,   65,      0, 1'b1, ST_OK,           16384, CLASS_MEDIUM, 1);
        add_row(CMD_ACQUIRE,  256,      0, 1'b1, ST_OK,           16640, CLASS_MEDIUM, 2);
        add_row(CMD_ACQUIRE,  257,      0, 1'b1, ST_OK,           49152, CLASS_LARGE,  1);
        add_row(CMD_ACQUIRE, 1024,      0, 1'b1, ST_OK,           50176, CLASS_LARGE,  2);
        add_row(CMD_ACQUIRE, 1025,      0, 1'b1, ST_TOO_LARGE,        0, CLASS_NONE,   0);
        add_row(CMD_ACQUIRE, 4095, 131071, 1'b1, ST_TOO_LARGE,        0, CLASS_NONE,   0);
        add_row(CMD_RELEASE, 4095,      0, 1'b1, ST_TOO_LARGE,        0, CLASS_NONE,   0);
        add_row(CMD_RELEASE,    1,  16384, 1'b1, ST_OUT_OF_RANGE,     0, CLASS_SMALL,  2);
        add_row(CMD_RELEASE,  200,  16383, 1'b1, ST_OUT_OF_RANGE,     0, CLASS_MEDIUM, 2);
        add_row(CMD_RELEASE, 1024, 114688, 1'b1, ST_OUT_OF_RANGE,     0, CLASS_LARGE,  2);
        add_row(CMD_RELEASE,  600, 131071, 1'b1, ST_OUT_OF_RANGE,     0, CLASS_LARGE,  2);
        add_row(CMD_RELEASE,   64,      0, 1'b1, ST_OK,               0, CLASS_SMALL,  1);
        add_row(CMD_RELEASE,   10,      7, 1'b1, ST_OK,               0, CLASS_SMALL,  0);
        add_row(CMD_RELEASE,   64,      0, 1'b1, ST_NONE_IN_USE,      0, CLASS_SMALL,  0);
        add_row(CMD_RELEASE,    0,  16383, 1'b1, ST_NONE_IN_USE,      0, CLASS_SMALL,  0);
        add_row(CMD_ACQUIRE,    1,      0, 1'b0, ST_OK,               0, CLASS_SMALL,  0);
        add_row(CMD_ACQUIRE,   64,      0, 1'b0, ST_OK,               0, CLASS_SMALL,  0);
        add_row(CMD_RELEASE,  300,  49152, 1'b0, ST_OK,               0, CLASS_SMALL,  0);
        add_row(CMD_RELEASE, 1000,  49152, 1'b0, ST_OK,               0, CLASS_SMALL,  0);
        add_row(CMD_RELEASE,  512,  49152, 1'b1, ST_NONE_IN_USE,      0, CLASS_LARGE,  0);
        add_row(CMD_ACQUIRE,  700,      0, 1'b0, ST_OK,               0, CLASS_SMALL,  0);
        add_row(CMD_RELEASE,  128,  32768, 1'b0, ST_OK,               0, CLASS_SMALL,  0);
        add_row(CMD_ACQUIRE,  129,      0, 1'b0, ST_OK,               0, CLASS_SMALL,  0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].has_fixed, directed_rows[i].fixed);

        // Phases cycle through filling each class to exhaustion, draining and mixed traffic.
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (phase_left == 0)
            begin
                phase_idx = (phase_idx + 1) % 6;
                phases_run++;
                case (phase_idx)
                    0:
                    begin
                        mode = MODE_FILL;  focus = 0;  phase_left = $urandom_range(300, 400);
                    end
                    1:
                    begin
                        mode = MODE_DRAIN; focus = -1; phase_left = $urandom_range(100, 200);
                    end
                    2:
                    begin
                        mode = MODE_FILL;  focus = 1;  phase_left = $urandom_range(150, 250);
                    end
                    3:
                    begin
                        mode = MODE_MIX;   focus = -1; phase_left = $urandom_range(100, 200);
                    end
                    4:
                    begin
                        mode = MODE_FILL;  focus = 2;  phase_left = $urandom_range(80, 150);
                    end
                    default:
                    begin
                        mode = MODE_DRAIN; focus = -1; phase_left = $urandom_range(150, 250);
                    end
                endcase
            end
            phase_left--;
            send_word(random_word(mode, focus), 1'b0, '0);
        end
        req_valid <= 1'b0;

        // Let every outstanding result arrive, then allow the pipeline to settle.
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d request words and checked %0d result words over %0d traffic phases.",
                 words_sent, results_seen, phases_run);
        $display("Outcomes: %0d ok, %0d exhausted, %0d too large, %0d out of range, %0d none in use.",
                 status_tally[ST_OK], status_tally[ST_EXHAUSTED], status_tally[ST_TOO_LARGE],
                 status_tally[ST_OUT_OF_RANGE], status_tally[ST_NONE_IN_USE]);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
